>>> src/assert_macros.svh
// Assertion macros shared by the RTL files in this folder.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever cond holds at a clock edge outside reset, expr holds at the same edge.
`define PBNC_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("Concurrent assertion failed.");

// Whenever cond holds at a clock edge outside reset, expr holds at the next edge.
`define PBNC_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("Concurrent assertion failed.");

`endif

>>> src/pbnc_pkg.sv
// Package for the palette blend nearest color core: fixed widths, codes and helpers.
// No dependencies; used by palette_blend_nearest_color_core through scoped names.
package pbnc_pkg;

   // Width of one color component and of a packed palette entry.
   localparam int COLOR_W = 8;
   localparam int ENTRY_W = 3 * COLOR_W;

   // Largest distance is 3 * 255 * 255, which fits in 18 bits.
   localparam int SQ_W   = 2 * COLOR_W;
   localparam int DIST_W = SQ_W + 2;

   // Stream payload widths.
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 8;

   // Kind of a request transaction, carried on req_tuser.
   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   // Query sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_A,
      ST_READ_B,
      ST_BLEND,
      ST_SCAN,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   // Squared difference of two color components.
   function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                               input logic [COLOR_W-1:0] b);
      logic [COLOR_W-1:0] diff;
      logic [SQ_W-1:0]    wide;
      diff = (a >= b) ? (a - b) : (b - a);
      wide = {{(SQ_W-COLOR_W){1'b0}}, diff};
      return wide * wide;
   endfunction

   // Truncating average of two color components.
   function automatic logic [COLOR_W-1:0] half_sum(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
      logic [COLOR_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[COLOR_W:1];
   endfunction

endpackage

>>> src/palette_blend_nearest_color_core.sv
// Palette blend nearest color core: palette memory, query sequencer and distance scan.
// Depends on pbnc_pkg and on assert_macros.svh for its assertions.
//
// Channel  Dir  Handshake                 Payload
// req      in   req_tvalid / req_tready   tuser = opcode, tdata = write and pair fields
// rsp      out  rsp_tvalid / rsp_tready   tdata = nearest_index
//
// A write transaction is stored at its acceptance edge.
// A query holds the input while it runs: two pair reads, one blend step, one
// palette read per entry on the single read port, and a two-stage distance and
// compare pipeline that drains after the last read.
// Reset clears the sequencer and the output register; palette contents persist
// and are undefined until written. The result waits in an output register, so
// a stalled rsp side does not block the next request transaction.
`include "assert_macros.svh"

module palette_blend_nearest_color_core #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Bits from low up: entry_index, red_level, green_level, blue_level,
   // first_color, second_color.
   input  logic [pbnc_pkg::REQ_TDATA_W-1:0] req_tdata,
   // Bit 0: opcode.
   input  logic                             req_tuser,
   // Result channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Bits from low up: nearest_index.
   output logic [pbnc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);
   localparam logic [8:0] ENTRY_LIMIT = 9'(PALETTE_ENTRIES);
   localparam int CW = pbnc_pkg::COLOR_W;

   // Request fields.
   logic [CW-1:0] req_entry_index;
   logic [CW-1:0] req_red_level;
   logic [CW-1:0] req_green_level;
   logic [CW-1:0] req_blue_level;
   logic [CW-1:0] req_first_color;
   logic [CW-1:0] req_second_color;
   logic          req_accept;

   assign req_entry_index  = req_tdata[7:0];
   assign req_red_level    = req_tdata[15:8];
   assign req_green_level  = req_tdata[23:16];
   assign req_blue_level   = req_tdata[31:24];
   assign req_first_color  = req_tdata[39:32];
   assign req_second_color = req_tdata[47:40];
   assign req_accept       = req_tvalid && req_tready;

   // Sequencer and pipeline registers.
   pbnc_pkg::state_type          state_ff, state_in;
   logic [IDX_W-1:0]             first_ff, first_in;
   logic [IDX_W-1:0]             second_ff, second_in;
   logic                         first_ok_ff, first_ok_in;
   logic                         second_ok_ff, second_ok_in;
   logic [pbnc_pkg::ENTRY_W-1:0] color_a_ff, color_a_in;
   logic [CW-1:0]                blend_r_ff, blend_r_in;
   logic [CW-1:0]                blend_g_ff, blend_g_in;
   logic [CW-1:0]                blend_b_ff, blend_b_in;
   logic [IDX_W-1:0]             scan_ff, scan_in;
   logic                         ent_vld_ff, ent_vld_in;
   logic                         ent_last_ff, ent_last_in;
   logic [IDX_W-1:0]             ent_idx_ff, ent_idx_in;
   logic                         dist_vld_ff, dist_vld_in;
   logic                         dist_last_ff, dist_last_in;
   logic [IDX_W-1:0]             dist_idx_ff, dist_idx_in;
   logic [pbnc_pkg::DIST_W-1:0]  dist_ff, dist_in;
   logic                         best_vld_ff, best_vld_in;
   logic [IDX_W-1:0]             best_idx_ff, best_idx_in;
   logic [pbnc_pkg::DIST_W-1:0]  best_d_ff, best_d_in;
   logic                         rsp_vld_ff, rsp_vld_in;
   logic [pbnc_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Palette memory, one write port and one registered read port.
   logic [pbnc_pkg::ENTRY_W-1:0] palette_mem [PALETTE_ENTRIES];
   logic [pbnc_pkg::ENTRY_W-1:0] rd_data_ff;
   logic                         rd_en;
   logic [IDX_W-1:0]             rd_addr;
   logic                         wr_en;
   logic                         rsp_load;

   // Writes land only while the sequencer is idle, and reads only happen during
   // a query, so a read never overlaps a write to the same entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         palette_mem[req_entry_index[IDX_W-1:0]] <=
            {req_red_level, req_green_level, req_blue_level};
      end
      if (rd_en) begin
         rd_data_ff <= palette_mem[rd_addr];
      end
   end

   // Next state of the query sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pbnc_pkg::ST_IDLE: begin
            if (req_accept && (req_tuser == pbnc_pkg::OP_QUERY)) begin
               state_in = pbnc_pkg::ST_READ_A;
            end
         end
         pbnc_pkg::ST_READ_A: state_in = pbnc_pkg::ST_READ_B;
         pbnc_pkg::ST_READ_B: state_in = pbnc_pkg::ST_BLEND;
         pbnc_pkg::ST_BLEND:  state_in = pbnc_pkg::ST_SCAN;
         pbnc_pkg::ST_SCAN: begin
            if (scan_ff == LAST_IDX) begin
               state_in = pbnc_pkg::ST_DRAIN;
            end
         end
         pbnc_pkg::ST_DRAIN: begin
            if (dist_vld_ff && dist_last_ff) begin
               state_in = pbnc_pkg::ST_RESULT;
            end
         end
         pbnc_pkg::ST_RESULT: begin
            if (!rsp_vld_ff || rsp_tready) begin
               state_in = pbnc_pkg::ST_IDLE;
            end
         end
         default: state_in = pbnc_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake, memory port controls and result load.
   // No transaction is taken while reset is asserted.
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = scan_ff;
      rsp_load   = 1'b0;
      case (state_ff)
         pbnc_pkg::ST_IDLE:   req_tready = !reset;
         pbnc_pkg::ST_READ_A: begin
            rd_en   = 1'b1;
            rd_addr = first_ff;
         end
         pbnc_pkg::ST_READ_B: begin
            rd_en   = 1'b1;
            rd_addr = second_ff;
         end
         pbnc_pkg::ST_SCAN:   rd_en = 1'b1;
         pbnc_pkg::ST_RESULT: rsp_load = !rsp_vld_ff || rsp_tready;
         default: begin
         end
      endcase
   end

   assign wr_en = req_accept && (req_tuser == pbnc_pkg::OP_WRITE) &&
                  ({1'b0, req_entry_index} < ENTRY_LIMIT);

   // Datapath next values.
   always_comb begin
      logic [pbnc_pkg::ENTRY_W-1:0] color_b;
      logic [pbnc_pkg::SQ_W-1:0]    sq_r;
      logic [pbnc_pkg::SQ_W-1:0]    sq_g;
      logic [pbnc_pkg::SQ_W-1:0]    sq_b;

      first_in     = first_ff;
      second_in    = second_ff;
      first_ok_in  = first_ok_ff;
      second_ok_in = second_ok_ff;
      color_a_in   = color_a_ff;
      blend_r_in   = blend_r_ff;
      blend_g_in   = blend_g_ff;
      blend_b_in   = blend_b_ff;
      scan_in      = scan_ff;
      best_vld_in  = best_vld_ff;
      best_idx_in  = best_idx_ff;
      best_d_in    = best_d_ff;
      rsp_vld_in   = rsp_vld_ff;
      rsp_data_in  = rsp_data_ff;

      // Latch the pair indices; an index beyond the palette reads as black.
      if (req_accept) begin
         first_in     = req_first_color[IDX_W-1:0];
         second_in    = req_second_color[IDX_W-1:0];
         first_ok_in  = {1'b0, req_first_color} < ENTRY_LIMIT;
         second_ok_in = {1'b0, req_second_color} < ENTRY_LIMIT;
      end

      // First pair entry arrives from the memory while the second is read.
      if (state_ff == pbnc_pkg::ST_READ_B) begin
         color_a_in = first_ok_ff ? rd_data_ff : '0;
      end

      // Second pair entry arrives; form the halfway color and arm the scan.
      color_b = second_ok_ff ? rd_data_ff : '0;
      if (state_ff == pbnc_pkg::ST_BLEND) begin
         blend_r_in  = pbnc_pkg::half_sum(color_a_ff[23:16], color_b[23:16]);
         blend_g_in  = pbnc_pkg::half_sum(color_a_ff[15:8], color_b[15:8]);
         blend_b_in  = pbnc_pkg::half_sum(color_a_ff[7:0], color_b[7:0]);
         scan_in     = '0;
         best_vld_in = 1'b0;
      end

      // Scan address walks the palette one entry per cycle.
      if (state_ff == pbnc_pkg::ST_SCAN) begin
         scan_in = scan_ff + IDX_W'(1);
      end

      // Tag of the entry now in the read register.
      ent_vld_in  = (state_ff == pbnc_pkg::ST_SCAN);
      ent_last_in = (scan_ff == LAST_IDX);
      ent_idx_in  = scan_ff;

      // Distance stage: squared RGB distance of the entry just read.
      sq_r = pbnc_pkg::sq_diff(blend_r_ff, rd_data_ff[23:16]);
      sq_g = pbnc_pkg::sq_diff(blend_g_ff, rd_data_ff[15:8]);
      sq_b = pbnc_pkg::sq_diff(blend_b_ff, rd_data_ff[7:0]);
      dist_in      = pbnc_pkg::DIST_W'(sq_r) + pbnc_pkg::DIST_W'(sq_g) +
                     pbnc_pkg::DIST_W'(sq_b);
      dist_vld_in  = ent_vld_ff;
      dist_last_in = ent_last_ff;
      dist_idx_in  = ent_idx_ff;

      // Compare stage: a strictly smaller distance wins, so ties keep the lower index.
      if (dist_vld_ff && (!best_vld_ff || (dist_ff < best_d_ff))) begin
         best_vld_in = 1'b1;
         best_idx_in = dist_idx_ff;
         best_d_in   = dist_ff;
      end

      // Output register drains on the rsp handshake and refills from the scan.
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = pbnc_pkg::RSP_TDATA_W'(best_idx_ff);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbnc_pkg::ST_IDLE;
         ent_vld_ff   <= 1'b0;
         dist_vld_ff  <= 1'b0;
         best_vld_ff  <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ent_vld_ff   <= ent_vld_in;
         dist_vld_ff  <= dist_vld_in;
         best_vld_ff  <= best_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      first_ff     <= first_in;
      second_ff    <= second_in;
      first_ok_ff  <= first_ok_in;
      second_ok_ff <= second_ok_in;
      color_a_ff   <= color_a_in;
      blend_r_ff   <= blend_r_in;
      blend_g_ff   <= blend_g_in;
      blend_b_ff   <= blend_b_in;
      scan_ff      <= scan_in;
      ent_last_ff  <= ent_last_in;
      ent_idx_ff   <= ent_idx_in;
      dist_ff      <= dist_in;
      dist_last_ff <= dist_last_in;
      dist_idx_ff  <= dist_idx_in;
      best_idx_ff  <= best_idx_in;
      best_d_ff    <= best_d_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The last distance of a scan moves the sequencer to the result state.
   `PBNC_ASSERT_NEXT(a_last_to_result, clock, reset,
      dist_vld_ff && dist_last_ff, state_ff == pbnc_pkg::ST_RESULT)
   // The scan pipeline is empty whenever a result is handed over.
   `PBNC_ASSERT_NOW(a_drained_at_result, clock, reset,
      state_ff == pbnc_pkg::ST_RESULT, !ent_vld_ff && !dist_vld_ff && best_vld_ff)
   // Entries only flow through the pipeline during a scan or its drain.
   `PBNC_ASSERT_NOW(a_entry_in_scan, clock, reset,
      ent_vld_ff, state_ff == pbnc_pkg::ST_SCAN || state_ff == pbnc_pkg::ST_DRAIN)
   // A query acceptance starts reading the pair on the next cycle.
   `PBNC_ASSERT_NEXT(a_query_starts, clock, reset,
      req_accept && (req_tuser == pbnc_pkg::OP_QUERY), state_ff == pbnc_pkg::ST_READ_A)

endmodule
